// ===== src/tbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsb_pkg: shared types and constants
// Command, result and register index definitions for the segmented byte buffer.
// ----------------------------------------------------------------------------
package tbsb_pkg;

  localparam int unsigned BufferDepth    = 64;
  localparam int unsigned MaxTerminators = 4;

  // Configuration register indexes
  localparam logic [2:0] CfgTermCount = 3'd0;
  localparam logic [2:0] CfgTerm0     = 3'd1;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_PEEK  = 2'd1,
    MODE_DISC  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] in_byte;
    logic [6:0] needed_space;
  } cmd_t;

  typedef struct packed {
    logic       overflow;
    logic [6:0] fill_level;
    logic       would_not_fit;
    logic       is_empty;
    logic       terminator_found;
    logic       last;
    logic       byte_valid;
    logic [7:0] out_byte;
  } res_t;

endpackage

// ===== src/tbsb_front.sv =====
// ----------------------------------------------------------------------------
// tbsb_front: command intake
// Decodes input beats into commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tbsb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   in_data_i,   // in_byte[7:0], needed_space[14:8]
  input  logic [1:0]    in_user_i,   // mode
  output logic          cmd_valid_o,
  output tbsb_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import tbsb_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.mode         = mode_e'(in_user_i);
    cmd_in.in_byte      = in_data_i[7:0];
    cmd_in.needed_space = in_data_i[14:8];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/tbsb_back.sv =====
// ----------------------------------------------------------------------------
// tbsb_back: command execution
// Byte store, segment scan, segment emission and result output register.
// ----------------------------------------------------------------------------
module tbsb_back #(
  parameter int unsigned DEPTH = tbsb_pkg::BufferDepth,
  parameter int unsigned MAXT  = tbsb_pkg::MaxTerminators
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  tbsb_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  input  logic [2:0]            term_count_i,
  input  logic [MAXT-1:0][7:0]  terms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tbsb_pkg::res_t        out_o
);
  import tbsb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DepthW = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_DISC = 4'b1000
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DepthW) s = s - DepthW;
    return s[AW-1:0];
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          is_peek_q, is_peek_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] rd_off_q, rd_off_d;
  logic [CW-1:0] len_q, len_d;
  logic          found_q, found_d;
  logic [CW-1:0] emit_q, emit_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] pend_off_q, pend_off_d;
  logic          out_valid_q, out_valid_d;
  res_t          out_q, out_d;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we, rd_en;
  logic [CW-1:0] rd_sel;
  logic          can_issue, match, load, last_beat;
  logic [2:0]    used_terms;
  logic [7:0]    free_space;
  logic [CW-1:0] fill_after;

  assign can_issue = !out_valid_q || out_ready_i;
  assign used_terms = (term_count_i > 3'(MAXT)) ? 3'(MAXT) : term_count_i;
  assign free_space = 8'(DEPTH) - 8'(count_q);

  // compare the byte just read against the active terminators
  always_comb begin
    match = 1'b0;
    for (int k = 0; k < int'(MAXT); k++) begin
      if ((3'(k) < used_terms) && (rd_data_q == terms_i[k])) match = 1'b1;
    end
  end

  assign load      = pend_q && can_issue;
  assign last_beat = (pend_off_q == len_q - CW'(1));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    is_peek_d   = is_peek_q;
    scan_d      = scan_q;
    rd_vld_d    = rd_vld_q;
    rd_off_d    = rd_off_q;
    len_d       = len_q;
    found_d     = found_q;
    emit_d      = emit_q;
    pend_d      = pend_q;
    pend_off_d  = pend_off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_sel      = (state_q == ST_EMIT) ? emit_q : scan_q;
    fill_after  = count_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.mode)
            MODE_PUSH: begin
              if (can_issue) begin
                cmd_pop_o   = 1'b1;
                out_valid_d = 1'b1;
                out_d       = '0;
                out_d.last  = 1'b1;
                if (count_q >= DepthC) begin
                  out_d.overflow = 1'b1;
                end else begin
                  mem_we     = 1'b1;
                  fill_after = count_q + CW'(1);
                  count_d    = fill_after;
                end
                out_d.fill_level = 7'(fill_after);
                out_d.is_empty   = (fill_after == '0);
              end
            end
            MODE_QUERY: begin
              if (can_issue) begin
                cmd_pop_o           = 1'b1;
                out_valid_d         = 1'b1;
                out_d               = '0;
                out_d.last          = 1'b1;
                out_d.would_not_fit = ({1'b0, cmd_i.needed_space} > free_space);
                out_d.fill_level    = 7'(count_q);
                out_d.is_empty      = (count_q == '0);
              end
            end
            MODE_PEEK, MODE_DISC: begin
              if (count_q == '0) begin
                // empty buffer: single result, nothing to scan
                if (can_issue) begin
                  cmd_pop_o      = 1'b1;
                  out_valid_d    = 1'b1;
                  out_d          = '0;
                  out_d.last     = 1'b1;
                  out_d.is_empty = 1'b1;
                end
              end else begin
                cmd_pop_o = 1'b1;
                is_peek_d = (cmd_i.mode == MODE_PEEK);
                scan_d    = '0;
                rd_vld_d  = 1'b0;
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_vld_q && (match || (rd_off_q == count_q - CW'(1)))) begin
          len_d    = rd_off_q + CW'(1);
          found_d  = match;
          rd_vld_d = 1'b0;
          emit_d   = '0;
          pend_d   = 1'b0;
          state_d  = is_peek_q ? ST_EMIT : ST_DISC;
        end else if (scan_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_off_d = scan_q;
          scan_d   = scan_q + CW'(1);
        end else begin
          rd_vld_d = 1'b0;
        end
      end

      ST_EMIT: begin
        if (load) begin
          out_valid_d            = 1'b1;
          out_d                  = '0;
          out_d.out_byte         = rd_data_q;
          out_d.byte_valid       = 1'b1;
          out_d.last             = last_beat;
          out_d.terminator_found = found_q;
          out_d.fill_level       = 7'(count_q);
          pend_d                 = 1'b0;
          if (last_beat) state_d = ST_IDLE;
        end
        if ((emit_q < len_q) && (!pend_q || load)) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_off_d = emit_q;
          emit_d     = emit_q + CW'(1);
        end
      end

      ST_DISC: begin
        if (can_issue) begin
          fill_after             = count_q - len_q;
          head_d                 = wrap_add(head_q, len_q);
          count_d                = fill_after;
          out_valid_d            = 1'b1;
          out_d                  = '0;
          out_d.last             = 1'b1;
          out_d.terminator_found = found_q;
          out_d.fill_level       = 7'(fill_after);
          out_d.is_empty         = (fill_after == '0);
          state_d                = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wrap_add(head_q, count_q)] <= cmd_i.in_byte;
    if (rd_en) rd_data_q <= mem_q[wrap_add(head_q, rd_sel)];
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    len_q      <= len_d;
    found_q    <= found_d;
    rd_off_q   <= rd_off_d;
    pend_off_q <= pend_off_d;
    is_peek_q  <= is_peek_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      emit_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      emit_q      <= emit_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count above depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_vld_q) |-> (rd_off_q < count_q))
    else $error("scan read beyond held bytes");

  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_EMIT))
    else $error("pending read byte outside emission");

  a_disc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISC) |-> (len_q != '0 && len_q <= count_q))
    else $error("bad discard length");

endmodule

// ===== src/terminator_segmented_byte_buffer.sv =====
// ----------------------------------------------------------------------------
// terminator_segmented_byte_buffer: serial byte buffer split by terminators
// Push, peek, discard and space query over a circular byte store.
// ----------------------------------------------------------------------------
// Push, query and empty peek/discard each give one registered result beat.
//   Peek of a k-byte segment: a scan of the k bytes, then k result beats.
// Discard of a k-byte segment: a scan of the k bytes, then one result beat.
// Push and query: one beat per cycle while results are accepted. A peek holds the
//   back end to scan, then emits one byte per cycle while results are accepted.
// Reset clears pointers, fill count, queue and terminator registers, not the store.
module terminator_segmented_byte_buffer #(
  parameter int unsigned BUFFER_DEPTH    = tbsb_pkg::BufferDepth,
  parameter int unsigned MAX_TERMINATORS = tbsb_pkg::MaxTerminators
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // in_byte[7:0], needed_space[14:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // mode
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte[7:0], terminator_found[8],
                                      // is_empty[9], would_not_fit[10],
                                      // fill_level[17:11], overflow[18], zero pad
  output logic [0:0]  m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // last
);
  import tbsb_pkg::*;

  logic [2:0]                       term_count_q;
  logic [MAX_TERMINATORS-1:0][7:0]  terms_q;
  logic                             cmd_valid, cmd_pop;
  cmd_t                             cmd;
  res_t                             res;

  // terminator registers; writes to indexes past the last terminator register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= 3'd0;
      terms_q      <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTermCount) term_count_q <= cfg_data_i[2:0];
      for (int k = 0; k < int'(MAX_TERMINATORS); k++) begin
        if (cfg_idx_i == CfgTerm0 + 3'(k)) terms_q[k] <= cfg_data_i;
      end
    end
  end

  // front: beat intake and command queue
  tbsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: store, scan and result generation
  tbsb_back #(
    .DEPTH (BUFFER_DEPTH),
    .MAXT  (MAX_TERMINATORS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .term_count_i (term_count_q),
    .terms_i      (terms_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // result beat packing
  assign m_axis_tdata = {5'b0, res.overflow, res.fill_level, res.would_not_fit,
                         res.is_empty, res.terminator_found, res.out_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.last;

endmodule
